// ----- sv/evlrs_pkg.sv -----
// Shared types and constants for the event log record sizer.
// Holds the request/response payload structs, parser phase enum and CSR indexes.
// No dependencies.
package evlrs_pkg;

   // Default size of the algorithm table (id-to-digest-size entries)
   localparam int MaxAlgsDefault = 4;
   // Table entries that software can write
   localparam int NumHashRegs = 4;

   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 32;
   localparam int AlgCountW = 3;
   localparam int LenW      = 33;
   localparam int FieldW    = 32;

   // CSR register indexes
   localparam logic [CsrIndexW-1:0] CSR_ALG_COUNT    = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_HASH_ENTRY_0 = 3'd1;

   // Response status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY   = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN    = 2'd2;
   localparam logic [1:0] STATUS_TERMINATOR = 2'd3;

   typedef enum logic [2:0] {
      PH_PCR,
      PH_TYPE,
      PH_COUNT,
      PH_ALG,
      PH_DIGEST,
      PH_DSIZE,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [7:0] log_byte;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      logic [LenW-1:0] record_length;
      logic [1:0]      status;
   } rsp_payload_type;

endpackage

// ----- sv/event_log_record_sizer.sv -----
// Event log record sizer: walks a crypto-agile measurement log one byte per request.
// Emits the byte length of each record, or an error status, at the record's last byte.
// Depends on evlrs_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data   (log_byte, restart)
//   rsp      out        rsp_valid / rsp_ready  rsp_data   (record_length, status)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One request is taken per cycle while no response is held untaken; its response, if
// any, is in the output register on the next cycle. The parser state update (33-bit
// length add, 32-bit skip counter, parallel table compare) is combinational logic.
// The request side stalls only while a response is held and not taken.
// Synchronous reset clears parser state, the halt flag and all CSRs.
module event_log_record_sizer #(
   parameter int MAX_ALGS = evlrs_pkg::MaxAlgsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  evlrs_pkg::req_payload_type         req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output evlrs_pkg::rsp_payload_type         rsp_data,
   input  logic                               csr_we,
   input  logic [evlrs_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [evlrs_pkg::CsrDataW-1:0]     csr_wdata
);

   localparam int NumStored = (MAX_ALGS < evlrs_pkg::NumHashRegs) ?
                              MAX_ALGS : evlrs_pkg::NumHashRegs;
   localparam int EffW      = $clog2(MAX_ALGS + 1) > evlrs_pkg::AlgCountW ?
                              $clog2(MAX_ALGS + 1) : evlrs_pkg::AlgCountW;
   localparam int LenW      = evlrs_pkg::LenW;
   localparam int FieldW    = evlrs_pkg::FieldW;

   // Configuration
   logic [evlrs_pkg::AlgCountW-1:0] alg_count_ff;
   logic [evlrs_pkg::CsrDataW-1:0]  hash_ff [NumStored];
   logic [evlrs_pkg::CsrDataW-1:0]  tab_entry [MAX_ALGS];
   logic [EffW-1:0]                 eff_algs;

   // Parser state
   evlrs_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [1:0]           pos_ff, pos_in, cur_pos;
   logic                 tzero_ff, tzero_in, cur_tzero;
   logic [2:0]           dleft_ff, dleft_in, cur_dleft;
   logic [7:0]           alg_lo_ff, alg_lo_in, cur_alg_lo;
   logic [FieldW-1:0]    acc_ff, acc_in, cur_acc;
   logic [FieldW-1:0]    skip_ff, skip_in, cur_skip;
   logic [LenW-1:0]      run_ff, run_in, cur_run;
   logic                 halted_ff, halted_in, cur_halted;

   // Per-request working values
   logic                 req_fire;
   logic [FieldW-1:0]    acc_or;
   logic [FieldW-1:0]    skip_dec;
   logic [15:0]          alg_id;
   logic                 alg_found;
   logic [15:0]          alg_size;
   logic                 res_valid;
   logic [1:0]           res_status;
   logic [LenW-1:0]      res_len;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   evlrs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Table view: writable entries, then fixed zero entries
   for (genvar g = 0; g < MAX_ALGS; g++) begin : g_tab
      if (g < NumStored) begin : g_reg
         assign tab_entry[g] = hash_ff[g];
      end else begin : g_zero
         assign tab_entry[g] = '0;
      end
   end

   assign eff_algs = (EffW'(alg_count_ff) < EffW'(MAX_ALGS)) ?
                     EffW'(alg_count_ff) : EffW'(MAX_ALGS);

   // Write CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         alg_count_ff <= '0;
      end else if (csr_we && csr_index == evlrs_pkg::CSR_ALG_COUNT) begin
         alg_count_ff <= csr_wdata[evlrs_pkg::AlgCountW-1:0];
      end
   end

   for (genvar g = 0; g < NumStored; g++) begin : g_hash
      always_ff @(posedge clock) begin
         if (reset) begin
            hash_ff[g] <= '0;
         end else if (csr_we &&
                      csr_index == evlrs_pkg::CsrIndexW'(evlrs_pkg::CSR_HASH_ENTRY_0 + g)) begin
            hash_ff[g] <= csr_wdata;
         end
      end
   end

   // Restart clears the parser before this byte is parsed
   always_comb begin
      if (req_data.restart) begin
         cur_phase  = evlrs_pkg::PH_PCR;
         cur_pos    = '0;
         cur_tzero  = 1'b0;
         cur_dleft  = '0;
         cur_alg_lo = '0;
         cur_acc    = '0;
         cur_skip   = '0;
         cur_run    = '0;
         cur_halted = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = pos_ff;
         cur_tzero  = tzero_ff;
         cur_dleft  = dleft_ff;
         cur_alg_lo = alg_lo_ff;
         cur_acc    = acc_ff;
         cur_skip   = skip_ff;
         cur_run    = run_ff;
         cur_halted = halted_ff;
      end
   end

   assign acc_or   = cur_acc | (FieldW'(req_data.log_byte) << {cur_pos, 3'b000});
   assign skip_dec = (cur_skip != '0) ? cur_skip - FieldW'(1) : cur_skip;
   assign alg_id   = {req_data.log_byte, cur_alg_lo};

   // Look up the algorithm id; the lowest matching entry wins
   always_comb begin
      alg_found = 1'b0;
      alg_size  = '0;
      for (int j = MAX_ALGS - 1; j >= 0; j--) begin
         if (EffW'(j) < eff_algs && tab_entry[j][15:0] == alg_id) begin
            alg_found = 1'b1;
            alg_size  = tab_entry[j][31:16];
         end
      end
   end

   // Advance the parser by one byte
   always_comb begin
      phase_in   = cur_phase;
      pos_in     = cur_pos;
      tzero_in   = cur_tzero;
      dleft_in   = cur_dleft;
      alg_lo_in  = cur_alg_lo;
      acc_in     = cur_acc;
      skip_in    = cur_skip;
      run_in     = cur_run + LenW'(1);
      halted_in  = cur_halted;
      res_valid  = 1'b0;
      res_status = evlrs_pkg::STATUS_OK;
      res_len    = '0;

      if (cur_halted) begin
         run_in = cur_run;
      end else begin
         case (cur_phase)
            evlrs_pkg::PH_PCR, evlrs_pkg::PH_TYPE,
            evlrs_pkg::PH_COUNT, evlrs_pkg::PH_DSIZE: begin
               if (cur_pos != 2'd3) begin
                  acc_in = acc_or;
                  pos_in = cur_pos + 2'd1;
               end else begin
                  pos_in = '0;
                  acc_in = '0;
                  case (cur_phase)
                     evlrs_pkg::PH_PCR: begin
                        phase_in = evlrs_pkg::PH_TYPE;
                     end
                     evlrs_pkg::PH_TYPE: begin
                        tzero_in = (acc_or == '0);
                        phase_in = evlrs_pkg::PH_COUNT;
                     end
                     evlrs_pkg::PH_COUNT: begin
                        if (acc_or > FieldW'(eff_algs)) begin
                           res_valid  = 1'b1;
                           res_status = evlrs_pkg::STATUS_TOO_MANY;
                           halted_in  = 1'b1;
                        end else begin
                           dleft_in = acc_or[2:0];
                           phase_in = (acc_or[2:0] != '0) ? evlrs_pkg::PH_ALG :
                                                             evlrs_pkg::PH_DSIZE;
                        end
                     end
                     default: begin
                        // Data length field
                        skip_in = acc_or;
                        if (acc_or == '0) begin
                           res_valid = 1'b1;
                           if (cur_tzero) begin
                              res_status = evlrs_pkg::STATUS_TERMINATOR;
                              halted_in  = 1'b1;
                           end else begin
                              res_len   = run_in;
                              phase_in  = evlrs_pkg::PH_PCR;
                              tzero_in  = 1'b0;
                              dleft_in  = '0;
                              alg_lo_in = '0;
                              skip_in   = '0;
                              run_in    = '0;
                           end
                        end else begin
                           phase_in = evlrs_pkg::PH_DATA;
                        end
                     end
                  endcase
               end
            end
            evlrs_pkg::PH_ALG: begin
               if (cur_pos == '0) begin
                  alg_lo_in = req_data.log_byte;
                  pos_in    = 2'd1;
               end else begin
                  pos_in    = '0;
                  alg_lo_in = '0;
                  if (!alg_found) begin
                     res_valid  = 1'b1;
                     res_status = evlrs_pkg::STATUS_UNKNOWN;
                     halted_in  = 1'b1;
                  end else begin
                     dleft_in = (cur_dleft != '0) ? cur_dleft - 3'd1 : cur_dleft;
                     if (alg_size != '0) begin
                        skip_in  = FieldW'(alg_size);
                        phase_in = evlrs_pkg::PH_DIGEST;
                     end else begin
                        phase_in = (dleft_in != '0) ? evlrs_pkg::PH_ALG :
                                                       evlrs_pkg::PH_DSIZE;
                     end
                  end
               end
            end
            evlrs_pkg::PH_DIGEST: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = (cur_dleft != '0) ? evlrs_pkg::PH_ALG : evlrs_pkg::PH_DSIZE;
               end
            end
            evlrs_pkg::PH_DATA: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  res_valid = 1'b1;
                  res_len   = run_in;
                  phase_in  = evlrs_pkg::PH_PCR;
                  pos_in    = '0;
                  tzero_in  = 1'b0;
                  dleft_in  = '0;
                  alg_lo_in = '0;
                  acc_in    = '0;
                  run_in    = '0;
               end
            end
            default: begin
               // Unused phase code: drop back to a clean parser
               phase_in  = evlrs_pkg::PH_PCR;
               pos_in    = '0;
               tzero_in  = 1'b0;
               dleft_in  = '0;
               alg_lo_in = '0;
               acc_in    = '0;
               skip_in   = '0;
               run_in    = '0;
               halted_in = 1'b0;
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= evlrs_pkg::PH_PCR;
         pos_ff    <= '0;
         tzero_ff  <= 1'b0;
         dleft_ff  <= '0;
         alg_lo_ff <= '0;
         acc_ff    <= '0;
         skip_ff   <= '0;
         run_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tzero_ff  <= tzero_in;
         dleft_ff  <= dleft_in;
         alg_lo_ff <= alg_lo_in;
         acc_ff    <= acc_in;
         skip_ff   <= skip_in;
         run_ff    <= run_in;
         halted_ff <= halted_in;
      end
   end

   // Load the response register, or drain it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && res_valid) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.record_length = res_len;
         rsp_data_in.status        = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A held response blocks new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response held");

   // Error responses carry no length
   a_error_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != evlrs_pkg::STATUS_OK) |->
      (rsp_data_ff.record_length == '0))
      else $error("error response with nonzero length");

   // An error response halts the parser
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && res_valid && res_status != evlrs_pkg::STATUS_OK) |=> halted_ff)
      else $error("parser not halted after error");

   // A halted parser produces nothing until restart
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && !req_data.restart) |-> !res_valid)
      else $error("response while halted");

   // Byte position only moves inside multi-byte fields
   a_pos_phase: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (phase_ff == evlrs_pkg::PH_PCR || phase_ff == evlrs_pkg::PH_TYPE ||
                          phase_ff == evlrs_pkg::PH_COUNT || phase_ff == evlrs_pkg::PH_DSIZE ||
                          phase_ff == evlrs_pkg::PH_ALG))
      else $error("byte position set outside a field");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for event_log_record_sizer: directed and random measurement-log streams.
// Predicts record lengths and error codes per accepted request and checks responses in order.
// Depends on evlrs_pkg and the event_log_record_sizer RTL.
module tb_top;

   localparam logic [evlrs_pkg::CsrIndexW-1:0] CSR_PAST_END =
      evlrs_pkg::CSR_HASH_ENTRY_0 + evlrs_pkg::CsrIndexW'(evlrs_pkg::NumHashRegs);

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   evlrs_pkg::req_payload_type          req_data;
   logic                                rsp_valid;
   logic                                rsp_ready;
   evlrs_pkg::rsp_payload_type          rsp_data;
   logic                                csr_we;
   logic [evlrs_pkg::CsrIndexW-1:0]     csr_index;
   logic [evlrs_pkg::CsrDataW-1:0]      csr_wdata;

   // register mirror
   logic [2:0]           cfg_alg_count;
   logic [31:0]          cfg_table [evlrs_pkg::NumHashRegs];

   // record walker mirror
   evlrs_pkg::phase_type         cur_phase;
   logic [1:0]                   field_byte;
   logic                         rec_type_zero;
   logic [31:0]                  digests_due;
   logic [7:0]                   alg_id_low;
   logic [31:0]                  field_value;
   logic [31:0]                  skip_count;
   logic [evlrs_pkg::LenW-1:0]   rec_length;
   logic                         halt_flag;

   evlrs_pkg::rsp_payload_type   expected_records [$];
   logic [7:0]                   log_bytes [$];
   int unsigned                  bytes_parsed;
   int unsigned                  mismatches;
   bit                           steady;

   event_log_record_sizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // stall the response side at random unless in a steady stretch
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 19);
   end

   // ---------------------------------------------------------------- prediction

   function automatic int unsigned active_algs();
      return (cfg_alg_count < evlrs_pkg::MaxAlgsDefault) ? int'(cfg_alg_count)
                                                         : evlrs_pkg::MaxAlgsDefault;
   endfunction

   // lowest matching entry within the active count wins
   function automatic bit lookup_alg(input logic [15:0] id, output logic [15:0] size);
      size = '0;
      for (int j = 0; j < active_algs(); j++) begin
         if (cfg_table[j][15:0] == id) begin
            size = cfg_table[j][31:16];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void restart_walk();
      cur_phase     = evlrs_pkg::PH_PCR;
      field_byte    = '0;
      rec_type_zero = 1'b0;
      digests_due   = '0;
      alg_id_low    = '0;
      field_value   = '0;
      skip_count    = '0;
      rec_length    = '0;
      halt_flag     = 1'b0;
   endfunction

   function automatic void record_error(input logic [1:0] code);
      evlrs_pkg::rsp_payload_type r;
      r.record_length = '0;
      r.status        = code;
      expected_records.push_back(r);
      halt_flag = 1'b1;
   endfunction

   function automatic void record_done();
      evlrs_pkg::rsp_payload_type r;
      r.record_length = rec_length;
      r.status        = evlrs_pkg::STATUS_OK;
      expected_records.push_back(r);
      restart_walk();
   endfunction

   function automatic void next_digest_or_size();
      cur_phase = (digests_due != 0) ? evlrs_pkg::PH_ALG : evlrs_pkg::PH_DSIZE;
   endfunction

   // advance the walker by one accepted request
   function automatic void size_log_byte(input evlrs_pkg::req_payload_type rq);
      logic [31:0] field;
      logic [15:0] dsize;
      if (rq.restart) restart_walk();
      if (!halt_flag) begin
         bytes_parsed++;
         rec_length = rec_length + 1'b1;
         case (cur_phase)
            evlrs_pkg::PH_PCR, evlrs_pkg::PH_TYPE,
            evlrs_pkg::PH_COUNT, evlrs_pkg::PH_DSIZE: begin
               field_value = field_value | (32'(rq.log_byte) << (8 * field_byte));
               if (field_byte != 2'd3) begin
                  field_byte = field_byte + 2'd1;
               end else begin
                  field       = field_value;
                  field_byte  = '0;
                  field_value = '0;
                  case (cur_phase)
                     evlrs_pkg::PH_PCR: cur_phase = evlrs_pkg::PH_TYPE;
                     evlrs_pkg::PH_TYPE: begin
                        rec_type_zero = (field == 0);
                        cur_phase     = evlrs_pkg::PH_COUNT;
                     end
                     evlrs_pkg::PH_COUNT: begin
                        if (field > active_algs()) begin
                           record_error(evlrs_pkg::STATUS_TOO_MANY);
                        end else begin
                           digests_due = field;
                           next_digest_or_size();
                        end
                     end
                     evlrs_pkg::PH_DSIZE: begin
                        skip_count = field;
                        if (field != 0) cur_phase = evlrs_pkg::PH_DATA;
                        else if (rec_type_zero) record_error(evlrs_pkg::STATUS_TERMINATOR);
                        else record_done();
                     end
                     default: ;
                  endcase
               end
            end
            evlrs_pkg::PH_ALG: begin
               if (field_byte == 2'd0) begin
                  alg_id_low = rq.log_byte;
                  field_byte = 2'd1;
               end else begin
                  field_byte = '0;
                  if (!lookup_alg({rq.log_byte, alg_id_low}, dsize)) begin
                     record_error(evlrs_pkg::STATUS_UNKNOWN);
                  end else begin
                     if (digests_due != 0) digests_due = digests_due - 1;
                     if (dsize != 0) begin
                        skip_count = 32'(dsize);
                        cur_phase  = evlrs_pkg::PH_DIGEST;
                     end else begin
                        next_digest_or_size();
                     end
                  end
                  alg_id_low = '0;
               end
            end
            evlrs_pkg::PH_DIGEST: begin
               if (skip_count != 0) skip_count = skip_count - 1;
               if (skip_count == 0) next_digest_or_size();
            end
            evlrs_pkg::PH_DATA: begin
               if (skip_count != 0) skip_count = skip_count - 1;
               if (skip_count == 0) record_done();
            end
            default: restart_walk();
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_records
      evlrs_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: length %0d status %0d",
                        rsp_data.record_length, rsp_data.status);
         end else begin
            want = expected_records.pop_front();
            if (rsp_data.record_length !== want.record_length ||
                rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected len %0d status %0d, got len %0d status %0d",
                           want.record_length, want.status,
                           rsp_data.record_length, rsp_data.status);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // send one request; returns at the edge that accepted it
   task automatic send_byte(input logic [7:0] value, input logic restart_bit);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{log_byte: value, restart: restart_bit};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      size_log_byte(req_data);
   endtask

   // hold requests until every expected record is back and the pipe is quiet
   task automatic drain_records();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_csrs(input logic [31:0] count_word, input logic [31:0] e0,
                               input logic [31:0] e1, input logic [31:0] e2,
                               input logic [31:0] e3);
      logic [31:0] entry [evlrs_pkg::NumHashRegs];
      entry = '{e0, e1, e2, e3};
      drain_records();
      csr_we        <= 1'b1;
      csr_index     <= evlrs_pkg::CSR_ALG_COUNT;
      csr_wdata     <= count_word;
      cfg_alg_count  = count_word[2:0];
      for (int k = 0; k < evlrs_pkg::NumHashRegs; k++) begin
         @(negedge clock);
         csr_index    <= evlrs_pkg::CSR_HASH_ENTRY_0 + evlrs_pkg::CsrIndexW'(k);
         csr_wdata    <= entry[k];
         cfg_table[k]  = entry[k];
      end
      // index past the register list must be dropped
      @(negedge clock);
      csr_index <= CSR_PAST_END + evlrs_pkg::CsrIndexW'($urandom_range(0, 2));
      csr_wdata <= $urandom;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void add_u16(input logic [15:0] v);
      log_bytes.push_back(v[7:0]);
      log_bytes.push_back(v[15:8]);
   endfunction

   function automatic void add_u32(input logic [31:0] v);
      add_u16(v[15:0]);
      add_u16(v[31:16]);
   endfunction

   function automatic void add_fill(input int unsigned n);
      repeat (n) log_bytes.push_back(8'($urandom));
   endfunction

   function automatic void add_header(input logic [31:0] pcr, input logic [31:0] kind,
                                      input logic [31:0] count);
      add_u32(pcr);
      add_u32(kind);
      add_u32(count);
   endfunction

   // append id and digest body; unknown ids get no body
   function automatic bit add_digest(input logic [15:0] id);
      logic [15:0] size;
      add_u16(id);
      if (!lookup_alg(id, size)) return 1'b0;
      add_fill(size);
      return 1'b1;
   endfunction

   function automatic void add_data(input logic [31:0] len);
      add_u32(len);
      add_fill(len);
   endfunction

   // send the built bytes; restart on the first one when the walker is not at a record start
   task automatic send_log(input logic force_restart);
      logic rs;
      rs = force_restart || halt_flag || cur_phase != evlrs_pkg::PH_PCR || field_byte != 0;
      foreach (log_bytes[i]) send_byte(log_bytes[i], rs && i == 0);
      log_bytes.delete();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_config();
      // no algorithms after reset: only digest-free records pass
      add_header(32'h0, 32'h1, 32'h0);
      add_data(0);
      send_log(1'b0);
      add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      add_u32(32'd2);
      log_bytes.push_back(8'h00);
      log_bytes.push_back(8'hFF);
      send_log(1'b0);
      // terminator, then bytes the halted walker drops
      add_header(32'h0, 32'h0, 32'h0);
      add_data(0);
      send_log(1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // any digest is too many
      add_header(32'h5, 32'h1, 32'h1);
      send_log(1'b0);
      add_header(32'h5, 32'h1, 32'hFFFF_FFFF);
      send_log(1'b0);
   endtask

   task automatic test_standard_banks();
      program_csrs(32'd4, 32'h0014_0004, 32'h0020_000B, 32'h0030_000C, 32'h0040_000D);
      add_header(32'h1, 32'h8000_0001, 32'd4);
      void'(add_digest(16'h0004));
      void'(add_digest(16'h000B));
      void'(add_digest(16'h000C));
      void'(add_digest(16'h000D));
      add_data(5);
      send_log(1'b0);
      add_header(32'h0, 32'h7, 32'd0);
      add_data(3);
      send_log(1'b0);
      // zero type with data is a plain record
      add_header(32'h2, 32'h0, 32'd1);
      void'(add_digest(16'h000B));
      add_data(1);
      send_log(1'b0);
      add_header(32'h3, 32'h1, 32'd1);
      void'(add_digest(16'h0005));
      send_log(1'b0);
      add_header(32'h4, 32'h1, 32'd5);
      send_log(1'b0);
      // terminator after digests
      add_header(32'h5, 32'h0, 32'd2);
      void'(add_digest(16'h0004));
      void'(add_digest(16'h000D));
      add_data(0);
      send_log(1'b0);
   endtask

   task automatic test_table_quirks();
      // oversized count, duplicate ids, zero-size entry and all-ones id
      program_csrs(32'd7, 32'h0003_1234, 32'h0009_1234, 32'h0000_0000, 32'h000A_FFFF);
      add_header(32'h1, 32'h1, 32'd2);
      void'(add_digest(16'h1234));
      void'(add_digest(16'h0000));
      add_data(0);
      send_log(1'b0);
      add_header(32'h2, 32'h1, 32'd4);
      void'(add_digest(16'h0000));
      void'(add_digest(16'h1234));
      void'(add_digest(16'h0000));
      void'(add_digest(16'hFFFF));
      add_data(1);
      send_log(1'b0);
      add_header(32'h3, 32'h1, 32'd5);
      send_log(1'b0);
      // entries past the active count are not searched
      program_csrs(32'd2, 32'h0003_1234, 32'h0009_1234, 32'h0000_0000, 32'h000A_FFFF);
      add_header(32'h4, 32'h1, 32'd1);
      void'(add_digest(16'hFFFF));
      send_log(1'b0);
      add_header(32'h5, 32'h1, 32'd3);
      send_log(1'b0);
   endtask

   task automatic test_restart_cases();
      // huge data length cut short by a restart
      add_header(32'h9, 32'h9, 32'h0);
      add_u32(32'hFFFF_FFFF);
      add_fill(5);
      send_log(1'b0);
      add_header(32'hA, 32'h2, 32'd1);
      void'(add_digest(16'h1234));
      add_data(2);
      send_log(1'b0);
      // restart inside a header
      add_header(32'h1, 32'h1, 32'h0);
      while (log_bytes.size() > 6) void'(log_bytes.pop_back());
      send_log(1'b0);
      add_header(32'h0, 32'h3, 32'h0);
      add_data(1);
      send_log(1'b0);
      // restart on a walker already at a record start
      add_header(32'h7, 32'h7, 32'h0);
      add_data(0);
      send_log(1'b1);
      // restart right after an error
      add_header(32'h1, 32'h1, 32'd7);
      send_log(1'b0);
      add_header(32'h2, 32'h2, 32'd0);
      add_data(4);
      send_log(1'b0);
   endtask

   task automatic random_record();
      int unsigned eff, count, pick;
      logic        known;
      eff  = active_algs();
      pick = $urandom_range(99);
      if (pick < 6) begin
         // noise: loose bytes with scattered restarts
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(19) == 0);
      end else begin
         if (pick < 14) count = $urandom | 32'h100;
         else count = $urandom_range(0, eff);
         add_header($urandom, ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom), count);
         if (count > eff) begin
            add_fill($urandom_range(0, 3));
         end else begin
            known = 1'b1;
            for (int d = 0; d < count; d++) begin
               if (!add_digest(($urandom_range(9) == 0) ? 16'($urandom)
                               : cfg_table[$urandom_range(0, eff - 1)][15:0])) begin
                  known = 1'b0;
                  break;
               end
            end
            pick = $urandom_range(9);
            if (known)
               add_data((pick < 2) ? 0 : (pick < 9) ? $urandom_range(1, 12)
                                                    : $urandom_range(13, 64));
         end
         // drop the tail now and then
         if ($urandom_range(11) == 0)
            repeat ($urandom_range(1, log_bytes.size() - 1)) void'(log_bytes.pop_back());
         send_log($urandom_range(9) == 0);
      end
   endtask

   task automatic test_random_stream();
      logic [31:0] entry [evlrs_pkg::NumHashRegs];
      logic [2:0]  cnt;
      int unsigned target;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0, 3:    cnt = 3'd4;
            1:       cnt = 3'd0;
            2:       cnt = 3'd7;
            default: cnt = 3'($urandom_range(0, 7));
         endcase
         for (int k = 0; k < evlrs_pkg::NumHashRegs; k++) begin
            entry[k][15:0]  = ($urandom_range(4) == 0 && k > 0)
                              ? entry[$urandom_range(0, k - 1)][15:0] : 16'($urandom);
            entry[k][31:16] = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
         end
         program_csrs({29'($urandom), cnt}, entry[0], entry[1], entry[2], entry[3]);
         steady = (p == 3);
         target = bytes_parsed + 130;
         while (bytes_parsed < target) random_record();
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      steady    = 1'b0;
      bytes_parsed  = 0;
      mismatches    = 0;
      cfg_alg_count = '0;
      for (int k = 0; k < evlrs_pkg::NumHashRegs; k++) cfg_table[k] = '0;
      restart_walk();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_standard_banks();
      test_table_quirks();
      test_restart_cases();
      test_random_stream();

      drain_records();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #16000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- event_log_record_sizer.f -----
sv/evlrs_pkg.sv
sv/event_log_record_sizer.sv
sim/tb_top.sv
